FILE: src/pibr_pkg.sv
// Shared types and constants for the pulse interval byte receiver.
`timescale 1ns / 1ps

package pibr_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int TIME_BITS_DEF    = 16;

    localparam int CHANNEL_W   = 2;
    localparam int EDGE_TIME_W = 16;
    localparam int THRESH_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int ACT_W       = 2;

    // item function codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [POS_W-1:0] IDLE_POS      = 4'd15;
    localparam logic [POS_W-1:0] DATA_BITS     = 4'd8;
    localparam logic [ACT_W-1:0] ACTIVITY_LOAD = 2'd2;

    typedef struct packed {
        logic                   func;
        logic [CHANNEL_W-1:0]   channel;
        logic [EDGE_TIME_W-1:0] edge_time;
    } t_in_item;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel_out;
        logic [BYTE_W-1:0]    data_byte;
        logic                 parity_error;
    } t_out_item;

    // per-channel frame progress
    typedef struct packed {
        logic [POS_W-1:0]  bit_position;
        logic [BYTE_W-1:0] shift_byte;
        logic              parity_acc;
    } t_frame_state;

    // write controls from the top level into the channel bank
    typedef struct packed {
        logic         edge_we;
        logic         tick;
        logic         start;
        t_frame_state state;
    } t_bank_upd;

endpackage

FILE: src/pibr_frame_step.sv
// Bit decode and frame advance for the channel addressed by one edge.
`timescale 1ns / 1ps

module pibr_frame_step #(
    parameter int TIME_BITS = pibr_pkg::TIME_BITS_DEF
) (
    input  logic                             i_active,
    input  logic [pibr_pkg::CHANNEL_W-1:0]   i_channel,
    input  logic [TIME_BITS-1:0]             i_now,
    input  logic [TIME_BITS-1:0]             i_last,
    input  logic [pibr_pkg::THRESH_W-1:0]    i_threshold,
    input  pibr_pkg::t_frame_state           i_cur,
    output pibr_pkg::t_frame_state           o_next,
    output logic                             o_start,
    output logic                             o_emit,
    output pibr_pkg::t_out_item              o_item
);

    logic [TIME_BITS-1:0] w_interval;
    logic                 w_bit;
    logic                 w_idle;
    logic                 w_data;

    // interval wraps modulo 2^TIME_BITS
    assign w_interval = i_now - i_last;
    assign w_bit      = (32'(w_interval) < 32'(i_threshold));
    assign w_idle     = (i_cur.bit_position > pibr_pkg::DATA_BITS);
    assign w_data     = (i_cur.bit_position < pibr_pkg::DATA_BITS);

    always_comb begin
        o_next = i_cur;
        if (w_idle) begin
            o_next.bit_position = '0;
            o_next.shift_byte   = '0;
            o_next.parity_acc   = 1'b0;
        end else begin
            o_next.parity_acc   = i_cur.parity_acc ^ w_bit;
            o_next.bit_position = i_cur.bit_position + 4'd1;
            if (w_data) begin
                o_next.shift_byte = i_cur.shift_byte
                                  | (8'(w_bit) << i_cur.bit_position[2:0]);
            end
        end
    end

    assign o_start = w_idle;
    // parity bit position completes the byte
    assign o_emit  = i_active && !w_idle && !w_data;

    assign o_item.channel_out  = i_channel;
    assign o_item.data_byte    = i_cur.shift_byte;
    assign o_item.parity_error = i_cur.parity_acc ^ w_bit;

endmodule

FILE: src/pibr_chan_bank.sv
// Per-channel receive state: frame progress, last edge time, activity count.
`timescale 1ns / 1ps

module pibr_chan_bank #(
    parameter int NUM_CHANNELS = pibr_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = pibr_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pibr_pkg::CHANNEL_W-1:0] i_channel,
    input  logic [TIME_BITS-1:0]           i_now,
    input  pibr_pkg::t_bank_upd            i_upd,
    output logic                           o_in_range,
    output pibr_pkg::t_frame_state         o_cur,
    output logic [TIME_BITS-1:0]           o_last
);

    pibr_pkg::t_frame_state         r_state [NUM_CHANNELS];
    logic [TIME_BITS-1:0]           r_last  [NUM_CHANNELS];
    logic [pibr_pkg::ACT_W-1:0]     r_act   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]        w_hit;

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            w_hit[c] = (32'(i_channel) == c);
        end
    end

    assign o_in_range = |w_hit;

    // one-hot read select
    always_comb begin
        o_cur  = '0;
        o_last = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (w_hit[c]) begin
                o_cur  = o_cur | r_state[c];
                o_last = o_last | r_last[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_state[c].bit_position <= pibr_pkg::IDLE_POS;
                r_state[c].shift_byte   <= '0;
                r_state[c].parity_acc   <= 1'b0;
                r_last[c]               <= '0;
                r_act[c]                <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (i_upd.tick) begin
                    if (r_act[c] != '0) begin
                        r_act[c] <= r_act[c] - 2'd1;
                    end else begin
                        r_state[c].bit_position <= pibr_pkg::IDLE_POS;
                    end
                end else if (i_upd.edge_we && w_hit[c]) begin
                    r_state[c] <= i_upd.state;
                    r_last[c]  <= i_now;
                    if (i_upd.start) begin
                        r_act[c] <= pibr_pkg::ACTIVITY_LOAD;
                    end
                end
            end
        end
    end

endmodule

FILE: src/pulse_interval_byte_receiver_unit.sv
// Top level of the pulse interval byte receiver.
`timescale 1ns / 1ps

// Four-channel single-wire receiver. Each input item is either a line edge
// (func = edge, with channel and a free-running timestamp) or a timeout tick
// that ages all channels at once. On an idle channel an edge opens a frame;
// each later edge decodes one bit, 1 when the time since the previous edge
// (modulo 2^TIME_BITS) is below bit_threshold. Eight data bits arrive LSB
// first, then a parity bit; the parity edge emits one result item carrying
// the channel, the byte and a parity error flag. Ticks and other edges emit
// nothing. Edges on a channel number at or above NUM_CHANNELS are dropped.
// Throughput is one item per clock while the input is not stalled, including
// back-to-back edges on the same channel: the whole channel update (read,
// decode, write back) happens while the item sits in the input register; the
// result then goes to the result register. The input stalls only while the
// input register holds a parity edge and the result register is occupied
// and stalled. The user must write bit_threshold through i_cfg_we/i_cfg_data
// only while the block is idle (not enforced by the block); it resets to zero.

module pulse_interval_byte_receiver_unit #(
    parameter int NUM_CHANNELS = pibr_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = pibr_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pibr_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pibr_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [pibr_pkg::THRESH_W-1:0] i_cfg_data
);

    logic                          r_in_valid;
    pibr_pkg::t_in_item            r_in;
    logic                          r_out_valid;
    pibr_pkg::t_out_item           r_out;
    logic [pibr_pkg::THRESH_W-1:0] r_threshold;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_process;
    logic                   w_is_edge;
    logic                   w_in_range;
    logic                   w_active;
    logic [31:0]            w_now32;
    logic [TIME_BITS-1:0]   w_now;
    logic [TIME_BITS-1:0]   w_last;
    pibr_pkg::t_frame_state w_cur;
    pibr_pkg::t_frame_state w_next;
    logic                   w_start;
    logic                   w_emit;
    pibr_pkg::t_out_item    w_item;
    pibr_pkg::t_bank_upd    w_upd;

    // timestamp fitted to the stored time width
    assign w_now32 = 32'(r_in.edge_time);
    assign w_now   = w_now32[TIME_BITS-1:0];

    assign w_is_edge = (r_in.func == pibr_pkg::FUNC_EDGE);
    assign w_active  = r_in_valid && w_is_edge && w_in_range;

    // result slot is free if empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // only a byte-completing edge needs the result slot
    assign w_process  = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_process;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_upd.edge_we = w_process && w_is_edge;
    assign w_upd.tick    = w_process && (r_in.func == pibr_pkg::FUNC_TICK);
    assign w_upd.start   = w_start;
    assign w_upd.state   = w_next;

    pibr_chan_bank #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_channel  (r_in.channel),
        .i_now      (w_now),
        .i_upd      (w_upd),
        .o_in_range (w_in_range),
        .o_cur      (w_cur),
        .o_last     (w_last)
    );

    pibr_frame_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_active    (w_active),
        .i_channel   (r_in.channel),
        .i_now       (w_now),
        .i_last      (w_last),
        .i_threshold (r_threshold),
        .i_cur       (w_cur),
        .o_next      (w_next),
        .o_start     (w_start),
        .o_emit      (w_emit),
        .o_item      (w_item)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_process && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process && w_emit) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
